FILE: rtl/cpu_hotplug_load_governor_top_defines.svh
// assertion macros shared by the governor rtl
// no dependencies
`ifndef CPU_HOTPLUG_LOAD_GOVERNOR_TOP_DEFINES_SVH
`define CPU_HOTPLUG_LOAD_GOVERNOR_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CHLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHLG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/chlg_pkg.sv
// shared types, constants and tables of the hotplug governor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package chlg_pkg;
    localparam int NumCpusMax = 4;
    localparam int NumCpusDef = 4;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    localparam logic [2:0] REG_LOCKED  = 3'd0;
    localparam logic [2:0] REG_TEST    = 3'd1;
    localparam logic [2:0] REG_EXCLUDE = 3'd2;
    localparam logic [2:0] REG_DISPLAY = 3'd3;
    localparam logic [2:0] REG_MINFREQ = 3'd4;
    localparam logic [2:0] REG_FULLPERF = 3'd5;
    localparam logic [2:0] REG_LOWMIN  = 3'd6;
    localparam logic [2:0] REG_PRESENT = 3'd7;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,    // capture the request
        CMD_CPU,     // sample one cpu, start load divide
        CMD_ACC,     // accumulate load quotient
        CMD_MUL,     // clock times sum
        CMD_AVG      // start average divide
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] cpu;
    } t_ctl;

    typedef struct packed {
        logic       div_busy;
        logic       bad_sample;
    } t_sts;

    function automatic logic [6:0] thr_low(input logic [1:0] r);
        unique case (r)
            2'd0: thr_low = 7'd0;
            2'd1: thr_low = 7'd6;
            2'd2: thr_low = 7'd27;
            default: thr_low = 7'd40;
        endcase
    endfunction

    function automatic logic [6:0] thr_high(input logic [1:0] r);
        unique case (r)
            2'd0: thr_high = 7'd15;
            2'd1: thr_high = 7'd33;
            2'd2: thr_high = 7'd45;
            default: thr_high = 7'd100;
        endcase
    endfunction

    function automatic logic [2:0] rate_up(input logic [1:0] r);
        unique case (r)
            2'd0: rate_up = 3'd1;
            2'd1: rate_up = 3'd4;
            2'd2: rate_up = 3'd4;
            default: rate_up = 3'd2;
        endcase
    endfunction

    function automatic logic [2:0] rate_down(input logic [1:0] r);
        unique case (r)
            2'd0: rate_down = 3'd1;
            2'd1: rate_down = 3'd4;
            2'd2: rate_down = 3'd2;
            default: rate_down = 3'd1;
        endcase
    endfunction

    // clamp a small signed count to 0..3
    function automatic logic [1:0] clamp_idx(input logic signed [3:0] v);
        if (v < 0) begin
            clamp_idx = 2'd0;
        end else if (v > 3) begin
            clamp_idx = 2'd3;
        end else begin
            clamp_idx = v[1:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/chlg_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module chlg_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quo
);
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [32:0] w_try;
    logic [33:0] w_sub;

    always_comb begin
        w_try = {r_rem[31:0], r_q[63]};
        w_sub = {1'b0, w_try} - {2'b0, r_den};
        n_cnt = r_cnt;
        n_q   = r_q;
        n_rem = r_rem;
        if (r_cnt != 7'd0) begin
            n_cnt = r_cnt - 7'd1;
            if (!w_sub[33]) begin
                n_rem = w_sub[32:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q   = {r_q[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= 33'd0;
            r_den <= i_den;
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quo  = r_q;
endmodule
`default_nettype wire

FILE: rtl/chlg_datapath.sv
// sample registers, previous times, load sum and minimum, average divide
// depends on chlg_pkg and chlg_div
`timescale 1ns / 1ps
`default_nettype none
`include "cpu_hotplug_load_governor_top_defines.svh"
module chlg_datapath #(
    parameter int NUM_CPUS = chlg_pkg::NumCpusDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire chlg_pkg::t_ctl    i_ctl,
    input  wire logic [63:0]       i_idle [NUM_CPUS],
    input  wire logic [63:0]       i_wall [NUM_CPUS],
    input  wire logic [31:0]       i_clock_khz,
    input  wire logic [31:0]       i_full_perf,
    output chlg_pkg::t_sts         o_sts,
    output logic [6:0]             o_min,
    output logic [63:0]            o_avg
);
    logic [63:0] r_prev_idle [NUM_CPUS];
    logic [63:0] r_prev_wall [NUM_CPUS];
    logic [63:0] r_idle [NUM_CPUS];
    logic [63:0] r_wall [NUM_CPUS];
    logic [31:0] r_clk;
    logic [9:0]  r_sum;
    logic [6:0]  r_min;
    logic [41:0] r_prod;
    logic        r_bad;
    logic [31:0] w_di, w_dw, w_dwn, w_den;
    logic [63:0] w_num, w_quo;
    logic        w_start, w_busy;
    logic [6:0]  w_ld;
    logic [1:0]  w_cpu;

    assign w_cpu = i_ctl.cpu;
    assign w_di  = r_idle[w_cpu] [31:0] - r_prev_idle[w_cpu][31:0];
    assign w_dw  = r_wall[w_cpu] [31:0] - r_prev_wall[w_cpu][31:0];
    assign w_dwn = (w_dw == 32'd0) ? 32'd1 : w_dw;
    assign w_ld  = w_quo[6:0];

    always_comb begin
        w_start = 1'b0;
        w_num   = 64'd0;
        w_den   = 32'd1;
        if (i_ctl.cmd == chlg_pkg::CMD_CPU) begin
            w_start = 1'b1;
            w_num   = 64'(w_dwn - w_di) * 64'd100;
            w_den   = w_dwn;
        end else if (i_ctl.cmd == chlg_pkg::CMD_AVG) begin
            w_start = 1'b1;
            w_num   = {22'd0, r_prod};
            w_den   = (i_full_perf == 32'd0) ? 32'd1 : i_full_perf;
        end
    end

    chlg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_busy (w_busy),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CPUS; k++) begin
                r_prev_idle[k] <= 64'd0;
                r_prev_wall[k] <= 64'd0;
            end
            r_bad <= 1'b0;
            r_sum <= 10'd0;
            r_min <= 7'd100;
        end else begin
            unique case (i_ctl.cmd)
                chlg_pkg::CMD_LOAD: begin
                    for (int k = 0; k < NUM_CPUS; k++) begin
                        r_idle[k] <= i_idle[k];
                        r_wall[k] <= i_wall[k];
                    end
                    r_clk <= i_clock_khz;
                    r_sum <= 10'd0;
                    r_min <= 7'd100;
                    r_bad <= 1'b0;
                end
                chlg_pkg::CMD_CPU: begin
                    r_prev_idle[w_cpu] <= r_idle[w_cpu];
                    r_prev_wall[w_cpu] <= r_wall[w_cpu];
                    r_bad <= (w_dw < w_di);
                end
                chlg_pkg::CMD_ACC: begin
                    r_sum <= r_sum + 10'(w_ld);
                    if (w_ld < r_min) begin
                        r_min <= w_ld;
                    end
                end
                chlg_pkg::CMD_MUL: begin
                    r_prod <= 42'(r_clk) * 42'(r_sum);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts = '{div_busy: w_busy, bad_sample: r_bad};
    assign o_min = r_min;
    assign o_avg = w_quo;

    `CHLG_ASSERT_IMP(a_min_range, i_clk, i_rst_n, 1'b1, r_min <= 7'd100)
    `CHLG_ASSERT_NXT(a_div_start, i_clk, i_rst_n, w_start, w_busy)
    `CHLG_ASSERT_IMP(a_sum_range, i_clk, i_rst_n, 1'b1, r_sum <= 10'd400)
endmodule
`default_nettype wire

FILE: rtl/chlg_ctrl.sv
// tick sequencer: handshake, sampling order, decision, cpu choice, results
// depends on chlg_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "cpu_hotplug_load_governor_top_defines.svh"
module chlg_ctrl #(
    parameter int NUM_CPUS = chlg_pkg::NumCpusDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [3:0]     i_online_mask,
    input  wire logic [15:0]    i_runnable_tasks,
    input  wire logic [31:0]    i_clock_khz,
    input  wire logic           i_locked,
    input  wire logic           i_test,
    input  wire logic [3:0]     i_exclude,
    input  wire logic           i_display,
    input  wire logic [31:0]    i_min_freq,
    input  wire logic [6:0]     i_low_min,
    input  wire logic [3:0]     i_present,
    output chlg_pkg::t_ctl      o_ctl,
    input  wire chlg_pkg::t_sts i_sts,
    input  wire logic [6:0]     i_min,
    input  wire logic [63:0]    i_avg,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [1:0]          o_action,
    output logic [1:0]          o_cpu_index,
    output logic [2:0]          o_next_delay_tenths,
    output logic                o_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CPU, S_WAITL, S_ACC, S_MUL, S_AVG, S_WAITA, S_DEC,
        S_OUT
    } t_state;

    localparam logic [3:0] AllMask = 4'((1 << NUM_CPUS) - 1);

    t_state      r_state;
    logic [3:0]  r_onl, r_free, r_pres;
    logic [15:0] r_runq;
    logic [31:0] r_clk;
    logic [2:0]  r_n;
    logic [1:0]  r_cpu;
    logic [1:0]  r_cc;
    logic [2:0]  r_delay;
    logic [1:0]  r_act  [3];
    logic [1:0]  r_idx  [3];
    logic [1:0]  r_cnt, r_pos;
    logic        r_out_valid;

    logic [3:0]  w_pres, w_onl;
    logic [2:0]  w_n;
    logic [1:0]  w_row;
    logic [6:0]  w_tl, w_th;
    logic        w_out_path, w_up;
    logic [2:0]  w_cc;
    logic [63:0] w_navg;

    assign w_pres = i_present & AllMask;
    assign w_onl  = i_online_mask & w_pres;
    assign w_n    = 3'(w_onl[0]) + 3'(w_onl[1]) + 3'(w_onl[2]) + 3'(w_onl[3]);
    assign w_row  = chlg_pkg::clamp_idx(4'(r_n) - 4'sd1);
    assign w_tl   = chlg_pkg::thr_low(w_row);
    assign w_th   = chlg_pkg::thr_high(w_row);
    // online count is at most four, so shift and add
    assign w_navg = (r_n[0] ? i_avg : 64'd0) + (r_n[1] ? {i_avg[62:0], 1'b0} : 64'd0)
                  + (r_n[2] ? {i_avg[61:0], 2'b0} : 64'd0);

    always_comb begin
        w_out_path = 1'b0;
        w_up       = 1'b0;
        if (r_n > 3'd1 && i_avg < 64'(w_tl)) begin
            w_out_path = 1'b1;
        end else if (32'(r_runq) > 32'(r_n) && i_avg > 64'(w_th) && r_clk > i_min_freq) begin
            w_up = 1'b1;
        end else if (r_n > 3'd1 && i_min < i_low_min) begin
            w_out_path = (w_navg < 64'd100 * 64'(r_n - 3'd1));
        end
        w_cc = 3'(r_cc) + ((i_avg <= 64'd10) ? 3'd2 : 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cc        <= 2'd0;
            r_delay     <= 3'd1;
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
            r_pos       <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_onl  <= w_onl;
                        r_pres <= w_pres;
                        r_free <= w_pres & ~i_exclude;
                        r_runq <= i_runnable_tasks;
                        r_clk  <= i_clock_khz;
                        r_n    <= w_n;
                        r_cnt  <= 2'd0;
                        r_pos  <= 2'd0;
                        r_cpu  <= 2'd0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (i_test) begin
                        // toggle 3, 2, 1 in turn
                        logic [1:0] c;
                        logic [2:0] d;
                        c = 2'd0;
                        d = r_delay;
                        for (int i = 3; i >= 1; i--) begin
                            if (r_free[i]) begin
                                r_idx[c] <= 2'(i);
                                if (!r_onl[i]) begin
                                    r_act[c] <= chlg_pkg::ACT_UP;
                                    if (i != 1) begin
                                        d = chlg_pkg::rate_up(chlg_pkg::clamp_idx(4'(r_n)));
                                    end
                                end else begin
                                    r_act[c] <= chlg_pkg::ACT_DOWN;
                                    if (i != 1) begin
                                        d = chlg_pkg::rate_down(
                                            chlg_pkg::clamp_idx(4'(r_n) - 4'sd1));
                                    end
                                end
                                c = c + 2'd1;
                            end
                        end
                        r_delay <= d;
                        r_cnt   <= c;
                        r_state <= S_OUT;
                    end else if (i_locked) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CPU;
                    end
                end
                S_CPU: begin
                    if (32'(r_cpu) >= NUM_CPUS) begin
                        r_state <= S_MUL;
                    end else if (r_onl[r_cpu]) begin
                        r_state <= S_WAITL;
                    end else if (32'(r_cpu) == NUM_CPUS - 1) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cpu <= r_cpu + 2'd1;
                    end
                end
                S_WAITL: begin
                    if (i_sts.bad_sample) begin
                        r_state <= S_OUT;
                    end else if (!i_sts.div_busy) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (32'(r_cpu) == NUM_CPUS - 1) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cpu   <= r_cpu + 2'd1;
                        r_state <= S_CPU;
                    end
                end
                S_MUL: r_state <= S_AVG;
                S_AVG: r_state <= S_WAITA;
                S_WAITA: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    logic [1:0] dn;
                    logic       found;
                    dn = chlg_pkg::ACT_NONE;
                    found = 1'b0;
                    if (w_up) begin
                        r_cc <= 2'd0;
                        dn = chlg_pkg::ACT_UP;
                    end else if (w_out_path) begin
                        if (w_cc > 3'd1) begin
                            r_cc <= 2'd0;
                            dn = chlg_pkg::ACT_DOWN;
                        end else begin
                            r_cc <= w_cc[1:0];
                        end
                    end
                    if (dn == chlg_pkg::ACT_UP) begin
                        // lowest offline cpu first
                        for (int i = 1; i <= 3; i++) begin
                            if (!found && r_free[i] && !r_onl[i]) begin
                                found = 1'b1;
                                r_act[0] <= chlg_pkg::ACT_UP;
                                r_idx[0] <= 2'(i);
                                r_cnt    <= 2'd1;
                                r_delay  <= chlg_pkg::rate_up(chlg_pkg::clamp_idx(4'(r_n)));
                            end
                        end
                    end else if (dn == chlg_pkg::ACT_DOWN) begin
                        // highest online cpu first
                        for (int i = 3; i >= 1; i--) begin
                            if (!found && r_free[i] && r_onl[i]) begin
                                found = 1'b1;
                                if (!(i == 1 && r_pres[2] && i_display)) begin
                                    r_act[0] <= chlg_pkg::ACT_DOWN;
                                    r_idx[0] <= 2'(i);
                                    r_cnt    <= 2'd1;
                                    r_delay  <= chlg_pkg::rate_down(
                                        chlg_pkg::clamp_idx(4'(r_n) - 4'sd2));
                                end
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        if (r_cnt == 2'd0) begin
                            r_act[0] <= chlg_pkg::ACT_NONE;
                            r_idx[0] <= 2'd0;
                            r_cnt    <= 2'd1;
                        end
                    end else if (i_out_ready) begin
                        if (r_pos == r_cnt - 2'd1) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_pos <= r_pos + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl.cmd = chlg_pkg::CMD_IDLE;
        o_ctl.cpu = r_cpu;
        if (r_state == S_IDLE && i_in_valid) begin
            o_ctl.cmd = chlg_pkg::CMD_LOAD;
        end else if (r_state == S_CPU && 32'(r_cpu) < NUM_CPUS && r_onl[r_cpu]) begin
            o_ctl.cmd = chlg_pkg::CMD_CPU;
        end else if (r_state == S_ACC) begin
            o_ctl.cmd = chlg_pkg::CMD_ACC;
        end else if (r_state == S_MUL) begin
            o_ctl.cmd = chlg_pkg::CMD_MUL;
        end else if (r_state == S_AVG) begin
            o_ctl.cmd = chlg_pkg::CMD_AVG;
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_action            = r_act[r_pos];
    assign o_cpu_index         = r_idx[r_pos];
    assign o_next_delay_tenths = r_delay;
    assign o_last              = (r_pos == r_cnt - 2'd1);

    `CHLG_ASSERT_IMP(a_out_in_out, i_clk, i_rst_n, r_out_valid, r_state == S_OUT)
    `CHLG_ASSERT_IMP(a_delay_rng, i_clk, i_rst_n, 1'b1, r_delay != 3'd0 && r_delay <= 3'd4)
    `CHLG_ASSERT_IMP(a_pos_rng, i_clk, i_rst_n, r_out_valid, r_pos < r_cnt)
endmodule
`default_nettype wire

FILE: rtl/cpu_hotplug_load_governor_top.sv
// A tick is taken when in_valid and in_ready meet; the block then works alone on it and
// gives one to three results. Unlocked, each online CPU takes a pass through the
// shared 64-step divider (load percentage), plus one more for the frequency-scaled
// average; locked or test-mode ticks skip the divider. A new request is taken only
// once the last result of a tick is delivered.
// Registers sit on the APB port at 4*index; pready is always high.
// depends on chlg_pkg, chlg_ctrl, chlg_datapath, chlg_div
`timescale 1ns / 1ps
`default_nettype none
module cpu_hotplug_load_governor_top #(
    parameter int NUM_CPUS = chlg_pkg::NumCpusDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_idle_us_0,
    input  wire logic [63:0] i_idle_us_1,
    input  wire logic [63:0] i_idle_us_2,
    input  wire logic [63:0] i_idle_us_3,
    input  wire logic [63:0] i_wall_us_0,
    input  wire logic [63:0] i_wall_us_1,
    input  wire logic [63:0] i_wall_us_2,
    input  wire logic [63:0] i_wall_us_3,
    input  wire logic [3:0]  i_online_mask,
    input  wire logic [15:0] i_runnable_tasks,
    input  wire logic [31:0] i_clock_khz,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_action,
    output logic [1:0]       o_cpu_index,
    output logic [2:0]       o_next_delay_tenths,
    output logic             o_last
);
    logic        r_locked, r_test, r_display;
    logic [3:0]  r_exclude, r_present;
    logic [31:0] r_min_freq, r_full_perf;
    logic [6:0]  r_low_min;
    logic [2:0]  w_addr;
    logic [63:0] w_idle_all [4];
    logic [63:0] w_wall_all [4];
    logic [63:0] w_idle [NUM_CPUS];
    logic [63:0] w_wall [NUM_CPUS];
    chlg_pkg::t_ctl w_ctl;
    chlg_pkg::t_sts w_sts;
    logic [6:0]  w_min;
    logic [63:0] w_avg;

    assign w_addr = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked    <= 1'b1;
            r_test      <= 1'b0;
            r_exclude   <= 4'd0;
            r_display   <= 1'b0;
            r_min_freq  <= 32'd96000;
            r_full_perf <= 32'd4000000;
            r_low_min   <= 7'd20;
            r_present   <= 4'd15;
        end else if (psel && penable && pwrite) begin
            unique case (w_addr)
                chlg_pkg::REG_LOCKED:   r_locked    <= pwdata[0];
                chlg_pkg::REG_TEST:     r_test      <= pwdata[0];
                chlg_pkg::REG_EXCLUDE:  r_exclude   <= pwdata[3:0];
                chlg_pkg::REG_DISPLAY:  r_display   <= pwdata[0];
                chlg_pkg::REG_MINFREQ:  r_min_freq  <= pwdata;
                chlg_pkg::REG_FULLPERF: r_full_perf <= pwdata;
                chlg_pkg::REG_LOWMIN:   r_low_min   <= pwdata[6:0];
                chlg_pkg::REG_PRESENT:  r_present   <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_addr)
            chlg_pkg::REG_LOCKED:   prdata = {31'd0, r_locked};
            chlg_pkg::REG_TEST:     prdata = {31'd0, r_test};
            chlg_pkg::REG_EXCLUDE:  prdata = {28'd0, r_exclude};
            chlg_pkg::REG_DISPLAY:  prdata = {31'd0, r_display};
            chlg_pkg::REG_MINFREQ:  prdata = r_min_freq;
            chlg_pkg::REG_FULLPERF: prdata = r_full_perf;
            chlg_pkg::REG_LOWMIN:   prdata = {25'd0, r_low_min};
            default:                prdata = {28'd0, r_present};
        endcase
    end

    assign w_idle_all = '{i_idle_us_0, i_idle_us_1, i_idle_us_2, i_idle_us_3};
    assign w_wall_all = '{i_wall_us_0, i_wall_us_1, i_wall_us_2, i_wall_us_3};
    always_comb begin
        for (int k = 0; k < NUM_CPUS; k++) begin
            w_idle[k] = w_idle_all[k];
            w_wall[k] = w_wall_all[k];
        end
    end

    chlg_datapath #(.NUM_CPUS(NUM_CPUS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idle     (w_idle),
        .i_wall     (w_wall),
        .i_clock_khz(i_clock_khz),
        .i_full_perf(r_full_perf),
        .o_sts      (w_sts),
        .o_min      (w_min),
        .o_avg      (w_avg)
    );

    chlg_ctrl #(.NUM_CPUS(NUM_CPUS)) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_online_mask      (i_online_mask),
        .i_runnable_tasks   (i_runnable_tasks),
        .i_clock_khz        (i_clock_khz),
        .i_locked           (r_locked),
        .i_test             (r_test),
        .i_exclude          (r_exclude),
        .i_display          (r_display),
        .i_min_freq         (r_min_freq),
        .i_low_min          (r_low_min),
        .i_present          (r_present),
        .o_ctl              (w_ctl),
        .i_sts              (w_sts),
        .i_min              (w_min),
        .i_avg              (w_avg),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_action           (o_action),
        .o_cpu_index        (o_cpu_index),
        .o_next_delay_tenths(o_next_delay_tenths),
        .o_last             (o_last)
    );
endmodule
`default_nettype wire
